>>> src/triangle_scanline_span_macros.svh
// Assertion macros shared by the span block.
`ifndef TRIANGLE_SCANLINE_SPAN_MACROS_SVH
`define TRIANGLE_SCANLINE_SPAN_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define TSS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types, constants and shade tables of the triangle scanline span block.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int SCREEN_W_DEF = 280;
  localparam int SCREEN_H_DEF = 240;
  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 12;
  localparam int NUM_W        = COORD_W + FRAC_BITS;
  localparam int QUO_W        = FRAC_BITS + 1;
  localparam int DIV_STAGES   = NUM_W;
  localparam int QUEUE_DEPTH  = 4;
  localparam logic [1:0] SHADE_MAX = 2'd3;

  typedef struct packed {
    logic                      go;
    logic [COORD_W-1:0]        num_a;
    logic [COORD_W-1:0]        den_a;
    logic [COORD_W-1:0]        num_b;
    logic [COORD_W-1:0]        den_b;
    logic signed [COORD_W:0]   dx_a;
    logic signed [COORD_W:0]   dx_b;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] xb;
    logic [1:0]                shade;
    logic                      even_lit;
    logic                      odd_lit;
  } span_job_t;

  function automatic logic [1:0] base_shade(input logic [1:0] kind);
    logic [1:0] r;
    case (kind)
      2'd1:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] face_offset(input logic [2:0] face);
    logic [1:0] r;
    case (face)
      3'd0:    r = 2'd1;
      3'd1:    r = 2'd2;
      3'd2:    r = 2'd1;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Returns {even, odd} pattern bits for a shade and row parity.
  function automatic logic [1:0] dither_bits(input logic [1:0] shade, input logic py);
    logic [1:0] r;
    case ({shade, py})
      3'b000:  r = 2'b01;
      3'b001:  r = 2'b00;
      3'b010:  r = 2'b10;
      3'b011:  r = 2'b01;
      3'b100:  r = 2'b11;
      3'b101:  r = 2'b10;
      default: r = 2'b11;
    endcase
    return r;
  endfunction

endpackage

>>> src/tss_front.sv
// ----------------------------------------------------------------------------
// tss_front
// Sorts the vertices by y, tests the row and prepares one span job.
// ----------------------------------------------------------------------------
module tss_front #(
  parameter int SCREEN_H = tss_pkg::SCREEN_H_DEF
) (
  input  logic signed [tss_pkg::COORD_W-1:0] ax,
  input  logic signed [tss_pkg::COORD_W-1:0] ay,
  input  logic signed [tss_pkg::COORD_W-1:0] bx,
  input  logic signed [tss_pkg::COORD_W-1:0] by,
  input  logic signed [tss_pkg::COORD_W-1:0] cx,
  input  logic signed [tss_pkg::COORD_W-1:0] cy,
  input  logic [7:0]                         row,
  input  logic [1:0]                         block_kind,
  input  logic [2:0]                         face,
  output tss_pkg::span_job_t                 job
);
  import tss_pkg::*;

  localparam logic signed [COORD_W:0] H_LIM = (COORD_W+1)'(SCREEN_H);

  logic signed [COORD_W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [COORD_W:0]   rs, ys, ye, y0e, y1e, y2e;
  logic signed [COORD_W:0]   d_tot, d_seg, d_na, d_nb;
  logic                      second;
  logic [2:0]                shade_sum;
  logic [1:0]                shade;
  logic [1:0]                dbits;

  // Three compare-and-swaps that move only on a strictly greater y.
  always_comb begin
    logic signed [COORD_W-1:0] tx, ty;
    tx = '0; ty = '0;
    x0 = ax; y0 = ay; x1 = bx; y1 = by; x2 = cx; y2 = cy;
    if (y0 > y1) begin
      tx = x0; ty = y0; x0 = x1; y0 = y1; x1 = tx; y1 = ty;
    end
    if (y0 > y2) begin
      tx = x0; ty = y0; x0 = x2; y0 = y2; x2 = tx; y2 = ty;
    end
    if (y1 > y2) begin
      tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
    end
  end

  always_comb begin
    y0e    = (COORD_W+1)'(y0);
    y1e    = (COORD_W+1)'(y1);
    y2e    = (COORD_W+1)'(y2);
    rs     = $signed({5'd0, row});
    ys     = (y0e < 0) ? '0 : y0e;
    ye     = (y2e > H_LIM) ? H_LIM : y2e;
    second = (rs > y1e) || (y1 == y0);
    d_tot  = y2e - y0e;
    d_seg  = second ? (y2e - y1e) : (y1e - y0e);
    d_na   = rs - y0e;
    d_nb   = rs - (second ? y1e : y0e);

    shade_sum = {1'b0, base_shade(block_kind)} + {1'b0, face_offset(face)};
    shade     = (shade_sum > {1'b0, SHADE_MAX}) ? SHADE_MAX : shade_sum[1:0];
    dbits     = dither_bits(shade, row[0]);

    job.go       = (d_tot != 0) && (rs >= ys) && (rs < ye) && (d_seg != 0);
    job.num_a    = d_na[COORD_W-1:0];
    job.den_a    = d_tot[COORD_W-1:0];
    job.num_b    = d_nb[COORD_W-1:0];
    job.den_b    = d_seg[COORD_W-1:0];
    job.dx_a     = (COORD_W+1)'(x2) - (COORD_W+1)'(x0);
    job.dx_b     = second ? ((COORD_W+1)'(x2) - (COORD_W+1)'(x1))
                          : ((COORD_W+1)'(x1) - (COORD_W+1)'(x0));
    job.xa       = x0;
    job.xb       = second ? x1 : x0;
    job.shade    = shade;
    job.even_lit = dbits[1];
    job.odd_lit  = dbits[0];
  end

endmodule

>>> src/tss_queue.sv
// ----------------------------------------------------------------------------
// tss_queue
// Short register queue of span jobs between the front and back parts.
// ----------------------------------------------------------------------------
module tss_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tss_pkg::span_job_t wr_job,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output tss_pkg::span_job_t rd_job
);
  import tss_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  span_job_t          slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_job    = slots_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> src/tss_div.sv
// ----------------------------------------------------------------------------
// tss_div
// Pipelined restoring divider of (num << 16) by den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module tss_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tss_pkg::COORD_W-1:0]   num,
  input  logic [tss_pkg::COORD_W-1:0]   den,
  output logic [tss_pkg::QUO_W-1:0]     quo
);
  import tss_pkg::*;

  logic [COORD_W-1:0] rem_r [DIV_STAGES];
  logic [COORD_W-1:0] den_r [DIV_STAGES];
  logic [NUM_W-1:0]   n_r   [DIV_STAGES];
  logic [NUM_W-1:0]   q_r   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [COORD_W-1:0] rem_in, den_in;
    logic [NUM_W-1:0]   n_in, q_in;
    logic [COORD_W:0]   trial;
    logic               fits;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den;
      assign n_in   = {num, {FRAC_BITS{1'b0}}};
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign n_in   = n_r[s-1];
      assign q_in   = q_r[s-1];
    end

    assign trial = {rem_in, n_in[NUM_W-1-s]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= fits ? COORD_W'(trial - {1'b0, den_in}) : trial[COORD_W-1:0];
        den_r[s] <= den_in;
        n_r[s]   <= n_in;
        q_r[s]   <= q_in | (NUM_W'(fits) << (NUM_W-1-s));
      end
    end
  end

  // The quotient never exceeds 2^16 for a live job.
  assign quo = q_r[DIV_STAGES-1][QUO_W-1:0];

endmodule

>>> src/tss_back.sv
// ----------------------------------------------------------------------------
// tss_back
// Interpolates both edges of queued jobs and orders and clamps the span.
// ----------------------------------------------------------------------------
module tss_back #(
  parameter int SCREEN_W = tss_pkg::SCREEN_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_avail,
  input  tss_pkg::span_job_t job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               span_valid,
  output logic [8:0]         span_start,
  output logic [8:0]         span_end,
  output logic [1:0]         shade_level,
  output logic               even_pixel_lit,
  output logic               odd_pixel_lit
);
  import tss_pkg::*;

  localparam int PROD_W = COORD_W + 1 + QUO_W + 1;
  localparam int SUM_W  = PROD_W - FRAC_BITS + 1;
  localparam logic signed [SUM_W-1:0] W_LIM = SUM_W'(SCREEN_W);

  logic                     en;
  logic                     vld_r [DIV_STAGES];
  span_job_t                pl_r  [DIV_STAGES];
  logic [QUO_W-1:0]         alpha, beta;
  logic                     mv_r;
  span_job_t                mpl_r;
  logic signed [PROD_W-1:0] prod_a_r, prod_b_r;
  logic signed [SUM_W-1:0]  ex_a, ex_b, lo, hi, lo_c, hi_c;
  logic                     ok;
  logic                     out_valid_r;
  logic                     span_valid_r;
  logic [8:0]               span_start_r, span_end_r;
  logic [1:0]               shade_r;
  logic                     even_r, odd_r;

  // The whole back pipeline moves together when the output register can load.
  assign en      = !out_valid_r || !out_stall;
  assign job_pop = en && job_avail;

  tss_div u_div_a (.clk(clk), .en(en), .num(job.num_a), .den(job.den_a), .quo(alpha));
  tss_div u_div_b (.clk(clk), .en(en), .num(job.num_b), .den(job.den_b), .quo(beta));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= job_avail;
      for (int i = 1; i < DIV_STAGES; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      mv_r        <= vld_r[DIV_STAGES-1];
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= job;
      for (int i = 1; i < DIV_STAGES; i++) begin
        pl_r[i] <= pl_r[i-1];
      end
      mpl_r    <= pl_r[DIV_STAGES-1];
      prod_a_r <= PROD_W'(pl_r[DIV_STAGES-1].dx_a * $signed({1'b0, alpha}));
      prod_b_r <= PROD_W'(pl_r[DIV_STAGES-1].dx_b * $signed({1'b0, beta}));
    end
  end

  // The arithmetic shift of the product floors toward minus infinity.
  always_comb begin
    ex_a = SUM_W'(mpl_r.xa) + SUM_W'(prod_a_r >>> FRAC_BITS);
    ex_b = SUM_W'(mpl_r.xb) + SUM_W'(prod_b_r >>> FRAC_BITS);
    lo   = (ex_a > ex_b) ? ex_b : ex_a;
    hi   = (ex_a > ex_b) ? ex_a : ex_b;
    lo_c = (lo < 0) ? '0 : lo;
    hi_c = (hi > W_LIM) ? W_LIM : hi;
    ok   = mpl_r.go && (lo_c < hi_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      span_valid_r <= ok;
      span_start_r <= ok ? lo_c[8:0] : 9'd0;
      span_end_r   <= ok ? hi_c[8:0] : 9'd0;
      shade_r      <= mpl_r.shade;
      even_r       <= mpl_r.even_lit;
      odd_r        <= mpl_r.odd_lit;
    end
  end

  assign out_valid      = out_valid_r;
  assign span_valid     = span_valid_r;
  assign span_start     = span_start_r;
  assign span_end       = span_end_r;
  assign shade_level    = shade_r;
  assign even_pixel_lit = even_r;
  assign odd_pixel_lit  = odd_r;

`include "triangle_scanline_span_macros.svh"
  `TSS_ASSERT(a_invalid_zero, (out_valid_r && !span_valid_r) |-> (span_start_r == 9'd0 && span_end_r == 9'd0), "invalid span beat carries a nonzero bound")
  `TSS_ASSERT(a_advance, (en && mv_r) |=> out_valid_r, "multiply stage beat was lost")
  `TSS_ASSERT(a_hold, (out_valid_r && out_stall) |=> (out_valid_r && $stable(span_start_r) && $stable(span_end_r)), "stalled result changed")
  `TSS_NEVER(a_pop_stall, job_pop && !en, "job taken while the pipeline is held")

endmodule

>>> src/triangle_scanline_span.sv
// ----------------------------------------------------------------------------
// triangle_scanline_span
// Path: an accepted input beat passes a queue slot, 28 divider stages, the multiply
// stage and the output stage; the dividers are fully pipelined, bit per stage.
// Throughput: one beat per cycle, set by the dividers, unless out_stall holds it.
// Reset: synchronous active-low rst_n empties the queue and the back pipeline.
// ----------------------------------------------------------------------------
module triangle_scanline_span #(
  parameter int SCREEN_W = tss_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H = tss_pkg::SCREEN_H_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [tss_pkg::COORD_W-1:0]  in_vertex_a_x,
  input  logic signed [tss_pkg::COORD_W-1:0]  in_vertex_a_y,
  input  logic signed [tss_pkg::COORD_W-1:0]  in_vertex_b_x,
  input  logic signed [tss_pkg::COORD_W-1:0]  in_vertex_b_y,
  input  logic signed [tss_pkg::COORD_W-1:0]  in_vertex_c_x,
  input  logic signed [tss_pkg::COORD_W-1:0]  in_vertex_c_y,
  input  logic [7:0]                          in_row,
  input  logic [1:0]                          in_block_kind,
  input  logic [2:0]                          in_face,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_span_valid,
  output logic [8:0]                          out_span_start,
  output logic [8:0]                          out_span_end,
  output logic [1:0]                          out_shade_level,
  output logic                                out_even_pixel_lit,
  output logic                                out_odd_pixel_lit
);
  import tss_pkg::*;

  span_job_t new_job, head_job;
  logic      q_full, q_avail, q_pop;

  tss_front #(.SCREEN_H(SCREEN_H)) u_front (
    .ax(in_vertex_a_x), .ay(in_vertex_a_y),
    .bx(in_vertex_b_x), .by(in_vertex_b_y),
    .cx(in_vertex_c_x), .cy(in_vertex_c_y),
    .row(in_row), .block_kind(in_block_kind), .face(in_face),
    .job(new_job)
  );

  assign in_stall = q_full;

  tss_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid && !q_full), .wr_job(new_job), .full(q_full),
    .pop(q_pop), .not_empty(q_avail), .rd_job(head_job)
  );

  tss_back #(.SCREEN_W(SCREEN_W)) u_back (
    .clk(clk), .rst_n(rst_n),
    .job_avail(q_avail), .job(head_job), .job_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .span_valid(out_span_valid), .span_start(out_span_start),
    .span_end(out_span_end), .shade_level(out_shade_level),
    .even_pixel_lit(out_even_pixel_lit), .odd_pixel_lit(out_odd_pixel_lit)
  );

endmodule
